### src/blsr_pkg.sv
// Shared types and constants for the bounded list store with remove-all.
`default_nettype none

package blsr_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int ELEM_WIDTH_DEF = 32;

    localparam int OP_W      = 2;
    localparam int DATA_W    = 32;
    localparam int INDEX_W   = 8;
    localparam int COUNT_W   = 9;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_SCAN = 2'd2
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } res_t;

endpackage

`default_nettype wire

### src/blsr_mem.sv
// Element memory: one write port and one registered read port.
`default_nettype none

module blsr_mem #(
    parameter int DEPTH = blsr_pkg::DEPTH_DEF,
    parameter int WIDTH = blsr_pkg::ELEM_WIDTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/blsr_ctrl.sv
// Sequencer and shared compare unit: append, indexed read, remove-all scan.
`default_nettype none

module blsr_ctrl #(
    parameter int DEPTH      = blsr_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = blsr_pkg::ELEM_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_accept,
    input  wire logic [blsr_pkg::OP_W-1:0]         in_op,
    input  wire logic [blsr_pkg::DATA_W-1:0]       in_value,
    input  wire logic [blsr_pkg::INDEX_W-1:0]      in_index,
    output logic                                   idle,
    output logic                                   mem_we,
    output logic      [$clog2(DEPTH)-1:0]          mem_waddr,
    output logic      [ELEM_WIDTH-1:0]             mem_wdata,
    output logic      [$clog2(DEPTH)-1:0]          mem_raddr,
    input  wire logic [ELEM_WIDTH-1:0]             mem_rdata,
    output blsr_pkg::res_t                         res,
    output logic                                   res_load
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > blsr_pkg::INDEX_W) ? CW : blsr_pkg::INDEX_W;

    blsr_pkg::state_t      state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         scan_reg, scan_next;
    logic [CW-1:0]         kept_reg, kept_next;
    logic                  pend_reg, pend_next;
    logic                  hit_reg, hit_next;
    logic [ELEM_WIDTH-1:0] value_reg, value_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= blsr_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg  <= scan_next;
        kept_reg  <= kept_next;
        hit_reg   <= hit_next;
        value_reg <= value_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        kept_next     = kept_reg;
        pend_next     = pend_reg;
        hit_next      = hit_reg;
        value_next    = value_reg;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[AW-1:0];
        mem_wdata     = ELEM_WIDTH'(in_value);
        mem_raddr     = AW'(in_index);
        res_load      = 1'b0;
        res.read_data = '0;
        res.status    = blsr_pkg::STAT_OK;

        unique case (state_reg)
            blsr_pkg::S_IDLE: begin
                if (in_accept) begin
                    case (in_op)
                        blsr_pkg::OP_APPEND: begin
                            if (count_reg == CW'(DEPTH)) begin
                                res.status = blsr_pkg::STAT_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            res_load = 1'b1;
                        end
                        blsr_pkg::OP_READ: begin
                            hit_next   = CMPW'(in_index) < CMPW'(count_reg);
                            state_next = blsr_pkg::S_READ;
                        end
                        blsr_pkg::OP_REMOVE: begin
                            value_next = ELEM_WIDTH'(in_value);
                            scan_next  = '0;
                            kept_next  = '0;
                            pend_next  = 1'b0;
                            state_next = blsr_pkg::S_SCAN;
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            blsr_pkg::S_READ: begin
                if (hit_reg) begin
                    res.read_data = blsr_pkg::DATA_W'(mem_rdata);
                end else begin
                    res.status = blsr_pkg::STAT_RANGE;
                end
                res_load   = 1'b1;
                state_next = blsr_pkg::S_IDLE;
            end
            blsr_pkg::S_SCAN: begin
                mem_raddr = scan_reg[AW-1:0];
                // keep survivors, compacting toward the front
                if (pend_reg && (mem_rdata != value_reg)) begin
                    mem_we    = 1'b1;
                    mem_waddr = kept_reg[AW-1:0];
                    mem_wdata = mem_rdata;
                    kept_next = kept_reg + 1'b1;
                end
                if (scan_reg < count_reg) begin
                    pend_next = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = kept_reg;
                        res_load   = 1'b1;
                        state_next = blsr_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                state_next = blsr_pkg::S_IDLE;
            end
        endcase

        res.count    = blsr_pkg::COUNT_W'(count_next);
        res.is_empty = (count_next == '0);
    end

    assign idle = (state_reg == blsr_pkg::S_IDLE);

endmodule

`default_nettype wire

### src/bounded_list_store_with_remove_all_core.sv
// Top level of the bounded list store with remove-all.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: op, value, index
//  m_      | out | m_tvalid/m_tready  | m_tdata: read_data, status, count, is_empty
//
// Append and the unused op code load their result in the accept cycle, read
// passes through S_READ (registered memory read), remove-all runs S_SCAN:
// one memory read and one compare per element via the single read port and
// shared comparator, then last write-back and finish (just finish if empty).
// aresetn clears the count and sequencer; memory contents stay undefined.
// A result is held until m_tready; s_tready stays low while an item is in
// work or an unaccepted result blocks the output register.
`default_nettype none

module bounded_list_store_with_remove_all_core #(
    parameter int DEPTH      = blsr_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = blsr_pkg::ELEM_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [1:0] op, [33:2] value, [41:34] index, [47:42] must be zero, not checked
    input  wire logic [blsr_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [31:0] read_data, [33:32] status, [42:34] count, [43] is_empty, [47:44] zero
    output logic      [blsr_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int AW = $clog2(DEPTH);

    logic                               s_accept;
    logic                               ctrl_idle;
    logic                               mem_we;
    logic [AW-1:0]                      mem_waddr;
    logic [ELEM_WIDTH-1:0]              mem_wdata;
    logic [AW-1:0]                      mem_raddr;
    logic [ELEM_WIDTH-1:0]              mem_rdata;
    blsr_pkg::res_t                     res;
    logic                               res_load;
    logic                               m_tvalid_reg;
    blsr_pkg::res_t                     m_res_reg;

    assign s_tready = ctrl_idle && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    blsr_ctrl #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_accept),
        .in_op     (s_tdata[1:0]),
        .in_value  (s_tdata[33:2]),
        .in_index  (s_tdata[41:34]),
        .idle      (ctrl_idle),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res       (res),
        .res_load  (res_load)
    );

    blsr_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_WIDTH)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, m_res_reg.is_empty, m_res_reg.count, m_res_reg.status,
                       m_res_reg.read_data};

    ap_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tdata[1:0] == blsr_pkg::OP_READ)) |=> !m_tvalid ##1 m_tvalid)
        else $error("read result not delivered two cycles after accept");

    ap_append_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tdata[1:0] == blsr_pkg::OP_APPEND)) |=> m_tvalid)
        else $error("append result not delivered in the next cycle");

    ap_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_res_reg.status == blsr_pkg::STAT_RANGE))
            |-> (m_res_reg.read_data == '0))
        else $error("out-of-range read returned nonzero data");

    ap_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_res_reg.count != '0)) |-> !m_res_reg.is_empty)
        else $error("empty flag set with nonzero count");

endmodule

`default_nettype wire
